// ===== src/jdq_pkg.sv =====
`timescale 1ns / 1ps
// jdq_pkg: shared types, zigzag map and IDCT basis weights for the JPEG
// dequantizer / inverse zigzag / 8x8 IDCT block. No dependencies.
package jdq_pkg;

  localparam int unsigned JDQ_QUANT_TABLES = 4;
  localparam int unsigned JDQ_CELLS        = 8;
  localparam int unsigned JDQ_COEF_W       = 20;  // dequantized coefficient
  localparam int unsigned JDQ_DATA_W       = 24;  // row pass value
  localparam int unsigned JDQ_W_W          = 15;  // Q1.14 weight
  localparam int unsigned JDQ_ACC_W        = 40;

  typedef struct packed {
    logic               mode;
    logic [1:0]         table_id;
    logic [5:0]         entry_index;
    logic [7:0]         entry_value;
    logic signed [11:0] coefficient;
  } jdq_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [5:0]         position;
    logic               last;
  } jdq_out_t;

  // control broadcast to the cell row
  typedef struct packed {
    logic       v;      // data valid for multiply
    logic       first;  // first term of a sum
    logic       col;    // column pass: weight shared by all cells
    logic [2:0] k;      // summation index
    logic [2:0] i;      // output row (column pass)
    logic       cap;    // load accumulators into the chain
    logic       shift;  // advance the chain toward cell 0
  } jdq_ctl_t;

  typedef enum logic [3:0] {
    S_IN, S_WAIT, S_RFEED, S_RWAIT, S_RWR, S_CFEED, S_CWAIT, S_CAP, S_SHIFT
  } jdq_state_e;

  localparam logic [5:0] NAT_OF_ZZ [64] = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

  // 0.5*cos(m*pi/16), Q1.14
  localparam logic signed [14:0] HALF_COS [32] = '{
     15'sd8192,  15'sd8035,  15'sd7568,  15'sd6811,
     15'sd5793,  15'sd4551,  15'sd3135,  15'sd1598,
     15'sd0,    -15'sd1598, -15'sd3135, -15'sd4551,
    -15'sd5793, -15'sd6811, -15'sd7568, -15'sd8035,
    -15'sd8192, -15'sd8035, -15'sd7568, -15'sd6811,
    -15'sd5793, -15'sd4551, -15'sd3135, -15'sd1598,
     15'sd0,     15'sd1598,  15'sd3135,  15'sd4551,
     15'sd5793,  15'sd6811,  15'sd7568,  15'sd8035
  };

  localparam logic signed [14:0] SQRT_EIGHTH = 15'sd5793;

  function automatic logic signed [14:0] basis(input logic [2:0] n, input logic [2:0] k);
    logic [6:0] m;
    m = {n, 1'b1} * k;
    if (k == 3'd0) return SQRT_EIGHTH;
    return HALF_COS[m[4:0]];
  endfunction

endpackage

// ===== src/jdq_cell.sv =====
`timescale 1ns / 1ps
// jdq_cell: one multiply-accumulate cell of the IDCT row, with a chain stage
// that hands finished sums to its neighbor. Depends on jdq_pkg.
module jdq_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  jdq_pkg::jdq_ctl_t                     ctl_i,
  input  logic signed [jdq_pkg::JDQ_DATA_W-1:0] data_i,
  input  logic signed [jdq_pkg::JDQ_ACC_W-1:0]  link_i,
  output logic signed [jdq_pkg::JDQ_ACC_W-1:0]  link_o,
  output logic signed [jdq_pkg::JDQ_ACC_W-1:0]  acc_o
);
  import jdq_pkg::*;

  localparam int unsigned PW = JDQ_DATA_W + JDQ_W_W;

  logic signed [JDQ_W_W-1:0]   w;
  logic signed [PW-1:0]        prod_q;
  logic                        pv_q, pf_q;
  logic signed [JDQ_ACC_W-1:0] acc_q, link_q;

  assign w = ctl_i.col ? basis(ctl_i.i, ctl_i.k) : basis(3'(IDX), ctl_i.k);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      pf_q <= 1'b0;
    end else begin
      pv_q <= ctl_i.v;
      pf_q <= ctl_i.first;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.v) prod_q <= data_i * w;
    if (pv_q) begin
      if (pf_q) acc_q <= JDQ_ACC_W'(prod_q);
      else      acc_q <= acc_q + JDQ_ACC_W'(prod_q);
    end
    if (ctl_i.cap)        link_q <= acc_q;
    else if (ctl_i.shift) link_q <= link_i;
  end

  assign link_o = link_q;
  assign acc_o  = acc_q;

endmodule

// ===== src/jpeg_dequant_izigzag_idct_8x8.sv =====
`timescale 1ns / 1ps
// jpeg_dequant_izigzag_idct_8x8: top level. Quant table store, dequantizer,
// inverse zigzag, sequencer and a row of eight jdq_cell. Depends on jdq_pkg.
//
//   channel | direction | handshake            | request
//   in      | sink      | in_valid_i/in_stall_o | jdq_in_t  (load or coefficient)
//   out     | source    | out_valid_o/out_stall_i | jdq_out_t (sample, raster order)
//
// Load and coefficient requests are taken one per cycle while the input is
// not stalled; the quant step read is registered at the accept and the
// multiply runs in the cycle after it. After the 64th coefficient the input
// stalls for the transform: a wait state, then per row the feed, pipeline
// wait and write of the row pass, then per output row the feed, pipeline
// wait, capture and shift of the column pass through the cell row.
// Output stalls only hold the chain; nothing is lost. Reset clears control
// state; the tables are undefined until loaded.
module jpeg_dequant_izigzag_idct_8x8 #(
  parameter int unsigned QUANT_TABLES = jdq_pkg::JDQ_QUANT_TABLES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  jdq_pkg::jdq_in_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output jdq_pkg::jdq_out_t out_req_o
);
  import jdq_pkg::*;

  localparam int unsigned QAW = $clog2(QUANT_TABLES * 64);

  // memories
  logic [7:0]                      qmem [QUANT_TABLES*64];
  logic signed [JDQ_COEF_W-1:0]    cmem [64];
  logic [JDQ_CELLS*JDQ_DATA_W-1:0] rmem [8];

  jdq_state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d, row_q, row_d;
  logic [5:0] zz_q;

  logic acc_in, acc_coef, tbl_ok;
  logic rd_c, rd_r, cap, shift, shift_en;

  // dequantizer stage
  logic                     pend_q, tok_q;
  logic signed [11:0]       coef_q;
  logic [5:0]               nat_q;
  logic [7:0]               step_q;
  logic signed [20:0]       prod;

  // cell feed
  logic v1_q, first1_q, col1_q;
  logic [2:0] k1_q, i1_q;
  logic signed [JDQ_COEF_W-1:0]    cdat_q;
  logic [JDQ_CELLS*JDQ_DATA_W-1:0] rdat_q;
  jdq_ctl_t ctl;

  logic signed [JDQ_ACC_W-1:0] acc  [JDQ_CELLS];
  logic signed [JDQ_ACC_W-1:0] link [JDQ_CELLS+1];
  logic [JDQ_CELLS*JDQ_DATA_W-1:0] row_word;

  // output
  logic                    out_valid_q;
  jdq_out_t                out_q;
  logic signed [JDQ_ACC_W-1:0] rnd;
  logic signed [15:0]      sat;

  assign in_stall_o = (state_q != S_IN);
  assign acc_in     = in_valid_i && !in_stall_o;
  assign acc_coef   = acc_in && !in_req_i.mode;
  assign tbl_ok     = 32'(in_req_i.table_id) < QUANT_TABLES;
  assign shift_en   = !out_valid_q || !out_stall_i;

  // quant table store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (acc_in && in_req_i.mode && tbl_ok)
      qmem[QAW'({in_req_i.table_id, in_req_i.entry_index})] <= in_req_i.entry_value;
    if (acc_coef) begin
      step_q <= qmem[QAW'({in_req_i.table_id, zz_q})];
      coef_q <= in_req_i.coefficient;
      nat_q  <= NAT_OF_ZZ[zz_q];
      tok_q  <= tbl_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      zz_q   <= '0;
    end else begin
      pend_q <= acc_coef;
      if (acc_coef) zz_q <= zz_q + 6'd1;
    end
  end

  // dequantize and place at natural position
  assign prod = coef_q * $signed({1'b0, (tok_q ? step_q : 8'd0)});

  always_ff @(posedge clk_i) begin
    if (pend_q) cmem[nat_q] <= JDQ_COEF_W'(prod);
    if (rd_c)   cdat_q <= cmem[{row_q, cnt_q}];
    if (rd_r)   rdat_q <= rmem[cnt_q];
    if (state_q == S_RWR) rmem[row_q] <= row_word;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
      cnt_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    row_d   = row_q;
    rd_c    = 1'b0;
    rd_r    = 1'b0;
    cap     = 1'b0;
    shift   = 1'b0;
    unique case (state_q)
      S_IN: begin
        if (acc_coef && zz_q == 6'd63) state_d = S_WAIT;
      end
      S_WAIT: begin
        state_d = S_RFEED;
        cnt_d   = '0;
        row_d   = '0;
      end
      S_RFEED: begin
        rd_c  = 1'b1;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) state_d = S_RWAIT;
      end
      S_RWAIT: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd1) begin
          state_d = S_RWR;
          cnt_d   = '0;
        end
      end
      S_RWR: begin
        row_d   = row_q + 3'd1;
        state_d = (row_q == 3'd7) ? S_CFEED : S_RFEED;
      end
      S_CFEED: begin
        rd_r  = 1'b1;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) state_d = S_CWAIT;
      end
      S_CWAIT: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd1) begin
          state_d = S_CAP;
          cnt_d   = '0;
        end
      end
      S_CAP: begin
        cap     = 1'b1;
        state_d = S_SHIFT;
        cnt_d   = '0;
      end
      S_SHIFT: begin
        if (shift_en) begin
          shift = 1'b1;
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            row_d   = row_q + 3'd1;
            state_d = (row_q == 3'd7) ? S_IN : S_CFEED;
          end
        end
      end
      default: state_d = S_IN;
    endcase
  end

  // feed pipeline, aligned with the registered memory reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      first1_q <= 1'b0;
      col1_q   <= 1'b0;
      k1_q     <= '0;
      i1_q     <= '0;
    end else begin
      v1_q     <= rd_c || rd_r;
      first1_q <= (cnt_q == 3'd0);
      col1_q   <= rd_r;
      k1_q     <= cnt_q;
      i1_q     <= row_q;
    end
  end

  assign ctl = '{v: v1_q, first: first1_q, col: col1_q, k: k1_q, i: i1_q,
                 cap: cap, shift: shift};

  assign link[JDQ_CELLS] = '0;

  for (genvar j = 0; j < JDQ_CELLS; j++) begin : g_cell
    logic signed [JDQ_DATA_W-1:0] d;
    logic signed [JDQ_ACC_W-1:0]  t;
    // row pass: coefficient broadcast; column pass: own column of the row word
    assign d = col1_q ? $signed(rdat_q[j*JDQ_DATA_W +: JDQ_DATA_W])
                      : JDQ_DATA_W'(cdat_q);
    jdq_cell #(.IDX(j)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .data_i (d),
      .link_i (link[j+1]),
      .link_o (link[j]),
      .acc_o  (acc[j])
    );
    // round half up to one fraction bit
    assign t = acc[j] + JDQ_ACC_W'(4096);
    assign row_word[j*JDQ_DATA_W +: JDQ_DATA_W] = t[36:13];
  end

  // column result: round half up to Q12.4 and saturate
  assign rnd = link[0] + JDQ_ACC_W'(1024);
  always_comb begin
    if ($signed(rnd[39:11]) > 29'sd32767)       sat = 16'sh7fff;
    else if ($signed(rnd[39:11]) < -29'sd32768) sat = 16'sh8000;
    else                                        sat = rnd[26:11];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (shift)        out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      out_q.sample   <= sat;
      out_q.position <= {row_q, cnt_q};
      out_q.last     <= (row_q == 3'd7) && (cnt_q == 3'd7);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== src/jdq_chk.sv =====
`timescale 1ns / 1ps
// jdq_chk: port checker for jpeg_dequant_izigzag_idct_8x8, bound to the top.
// Depends on jdq_pkg.
module jdq_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input jdq_pkg::jdq_in_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input jdq_pkg::jdq_out_t out_req_o
);
  import jdq_pkg::*;

  // last marks exactly the final raster position
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.last == (out_req_o.position == 6'd63)))
    else $error("last flag and position disagree");

  // no new request is taken while a block is still being emitted
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_req_o.last) |-> in_stall_o)
    else $error("input open during block output");

  // a taken non-final sample is followed by the next raster position
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_req_o.last) ##1 out_valid_o
      |-> out_req_o.position == $past(out_req_o.position) + 6'd1)
    else $error("sample order broken");

  // stalled request holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_req_o)))
    else $error("stalled output changed");

endmodule

bind jpeg_dequant_izigzag_idct_8x8 jdq_chk u_jdq_chk (.*);

// ===== tb/jdq_checker.sv =====
`timescale 1ns / 1ps
// jdq_checker: watches both channels of the JPEG dequant/IDCT block, predicts
// the sample stream and compares it. Depends on jdq_pkg.
module jdq_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  jdq_pkg::jdq_in_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  jdq_pkg::jdq_out_t out_req_i,
  output int                fail_count_o,
  output int                pending_o
);
  import jdq_pkg::*;

  logic [7:0]   qtab [4][64];
  int           block_buf [64];
  logic [5:0]   zz_pos;
  jdq_out_t     sample_q [$];

  function automatic longint weight(int n, int k);
    if (k == 0) return 5793;
    return HALF_COS[((2 * n + 1) * k) & 31];
  endfunction

  // floor((v + 2^(s-1)) / 2^s)
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  task automatic predict_block();
    longint rows [64];
    longint acc;
    longint r;
    jdq_out_t o;
    for (int x = 0; x < 8; x++)
      for (int j = 0; j < 8; j++) begin
        acc = 0;
        for (int y = 0; y < 8; y++) acc += weight(j, y) * block_buf[x * 8 + y];
        rows[x * 8 + j] = rnd_shift(acc, 13);
      end
    for (int k = 0; k < 64; k++) begin
      acc = 0;
      for (int x = 0; x < 8; x++) acc += weight(k >> 3, x) * rows[x * 8 + (k & 7)];
      r = rnd_shift(acc, 11);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      o.sample   = 16'(r);
      o.position = 6'(k);
      o.last     = (k == 63);
      sample_q.insert(sample_q.size(), o);
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("error at %0t: %s got %0d want %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;
  initial pending_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    jdq_out_t want;
    int step;
    if (!rst_ni) begin
      zz_pos <= '0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (in_req_i.mode) begin
          qtab[in_req_i.table_id][in_req_i.entry_index] = in_req_i.entry_value;
        end else begin
          step = qtab[in_req_i.table_id][zz_pos];
          block_buf[NAT_OF_ZZ[zz_pos]] = int'(in_req_i.coefficient) * step;
          if (zz_pos == 6'd63) predict_block();
          zz_pos <= zz_pos + 6'd1;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (sample_q.size() == 0) begin
          report("unexpected sample at position", out_req_i.position, -1);
        end else begin
          want = sample_q.pop_front();
          if (out_req_i.sample !== want.sample) report("sample", out_req_i.sample, want.sample);
          if (out_req_i.position !== want.position)
            report("position", out_req_i.position, want.position);
          if (out_req_i.last !== want.last) report("last", out_req_i.last, want.last);
        end
      end
    end
    pending_o = sample_q.size();
  end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for jpeg_dequant_izigzag_idct_8x8; prediction
// and comparison live in jdq_checker. Depends on jdq_pkg and the block.
module tb_top;
  import jdq_pkg::*;

  localparam int IDLE_PCT = 22;
  localparam int WATCHDOG = 20000;  // idle cycles before the watchdog stops the run

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  jdq_in_t  in_req;
  logic     out_valid;
  logic     out_stall;
  jdq_out_t out_req;
  int       fail_count;
  int       pending;
  int       quiet_cycles;
  bit       no_idle;   // a stretch with both sides always ready

  jpeg_dequant_izigzag_idct_8x8 dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_req_o(out_req)
  );

  jdq_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_req_i(out_req),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Receiver stalls at random, except in the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("jpeg_dequant_izigzag_idct_8x8: mismatch");
      $finish;
    end
  end

  // Sends one request, with a random gap in front unless in the quiet stretch.
  task automatic send(jdq_in_t req);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_entry(int tbl, int idx, int val);
    jdq_in_t r;
    r = '0;
    r.mode = 1'b1;
    r.table_id = 2'(tbl);
    r.entry_index = 6'(idx);
    r.entry_value = 8'(val);
    r.coefficient = 12'($urandom);  // don't-care on a load
    send(r);
  endtask

  task automatic send_coef(int tbl, int coef);
    jdq_in_t r;
    r = '0;
    r.table_id = 2'(tbl);
    r.entry_index = 6'($urandom);   // don't-care on a coefficient
    r.entry_value = 8'($urandom);
    r.coefficient = 12'(coef);
    send(r);
  endtask

  initial begin
    int t;
    int v;
    int c;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    out_stall = 1'b0;
    no_idle = 1'b0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One block, its coefficients cycling over the four tables. The step each reads is
    // loaded right before it, so loads land mid-block. Full-scale DC drives
    // the outputs into saturation; steps mix zero, one, full scale, random.
    for (int z = 0; z < 64; z++) begin
      no_idle = (z >= 24 && z < 56);
      t = z & 3;
      if (z == 0) begin
        v = 255;
      end else begin
        case ($urandom_range(3))
          0: v = 0;
          1: v = 1;
          2: v = 255;
          default: v = $urandom_range(255);
        endcase
      end
      if (z == 0)                      c = 2047;
      else if (z == 1)                 c = -2048;
      else if ($urandom_range(2) == 0) c = 0;
      else                             c = $signed(12'($urandom));
      load_entry(t, z, v);
      send_coef(t, c);
    end

    // Hold off until every expected sample has drained; the first half is
    // taken with no output stalls.
    in_valid <= 1'b0;
    @(posedge clk);
    no_idle = 1'b1;
    while (pending > 32) @(posedge clk);
    no_idle = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    // A few loads after the drain.
    for (int i = 0; i < 4; i++) load_entry(i, $urandom_range(63), $urandom_range(255));
    in_valid <= 1'b0;

    quiet_cycles = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("jpeg_dequant_izigzag_idct_8x8: match");
    end else begin
      $display("jpeg_dequant_izigzag_idct_8x8: mismatch");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/jdq_pkg.sv
src/jdq_cell.sv
src/jpeg_dequant_izigzag_idct_8x8.sv
src/jdq_chk.sv
tb/jdq_checker.sv
tb/tb_top.sv
